### hdl/csdm_pkg.sv
// ----------------------------------------------------------------------------
// csdm_pkg: shared types and constants of the concentric disk mapper
// Holds the fixed-point formats, the stage words and the arctangent table.
// ----------------------------------------------------------------------------
package csdm_pkg;

  // Fixed-point formats.
  localparam int unsigned FRAC_BITS        = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 18;
  localparam int unsigned IN_W   = FRAC_BITS;        // unit-square coordinate
  localparam int unsigned XY_W   = FRAC_BITS + 2;    // centered coordinate
  localparam int unsigned MAG_W  = FRAC_BITS + 1;    // magnitude, up to 1.0
  localparam int unsigned QBITS  = FRAC_BITS + 1;    // quotient bits
  localparam int unsigned REM_W  = 2 * FRAC_BITS + 2;
  localparam int unsigned OUT_W  = FRAC_BITS + 2;
  localparam int unsigned ANG_W  = 32;               // binary turns
  localparam int unsigned Z_W    = ANG_W + 1;
  localparam int unsigned GUARD  = 16;
  localparam int unsigned CXY_W  = FRAC_BITS + GUARD + 4;
  localparam int unsigned KG_W   = 30;
  localparam int unsigned PROD_W = MAG_W + KG_W;
  localparam int unsigned OCT_SH = 29;               // one octant = 2^29 units of 2^-32 turn
  localparam logic [KG_W-1:0] KGAIN_Q30 = KG_W'(652032875);

  // Octant offset of the selected region.
  typedef enum logic [1:0] {
    OCT0 = 2'd0,
    OCT2 = 2'd1,
    OCT4 = 2'd2,
    OCT6 = 2'd3
  } oct_e;

  // Word handed along the divider cells.
  typedef struct packed {
    logic             valid;
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] den;
    logic [QBITS-1:0] quo;
    logic             neg;
    oct_e             oct;
    logic [MAG_W-1:0] r;
  } div_t;

  // Word handed along the rotation cells.
  typedef struct packed {
    logic                    valid;
    logic [1:0]              quad;
    logic signed [CXY_W-1:0] cx;
    logic signed [CXY_W-1:0] cy;
    logic signed [Z_W-1:0]   z;
  } cord_t;

  // atan(2^-i) in 2^-32 turns.
  function automatic logic [ANG_W-1:0] atan_turn(input int unsigned idx);
    logic [ANG_W-1:0] v;
    case (idx)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### hdl/csdm_if.sv
// ----------------------------------------------------------------------------
// csdm_if: valid/ready channels of the concentric disk mapper
// One interface for the sample words and one for the disk words.
// ----------------------------------------------------------------------------
interface csdm_sample_if import csdm_pkg::*;;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] sample_u;
  logic [IN_W-1:0] sample_v;

  modport source (output valid, output sample_u, output sample_v, input ready);
  modport sink   (input valid, input sample_u, input sample_v, output ready);
endinterface

interface csdm_disk_if import csdm_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] disk_x;
  logic signed [OUT_W-1:0] disk_y;

  modport source (output valid, output disk_x, output disk_y, input ready);
  modport sink   (input valid, input disk_x, input disk_y, output ready);
endinterface

### hdl/csdm_div_cell.sv
// ----------------------------------------------------------------------------
// csdm_div_cell: one restoring-division cell
// Resolves one quotient bit of the ratio and passes the word on.
// ----------------------------------------------------------------------------
module csdm_div_cell import csdm_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  div_t div_i,
  output div_t div_o
);

  logic [REM_W-1:0] den_sh;
  div_t             div_d;
  div_t             div_q;

  // Compare against the shifted divisor and subtract when it fits.
  always_comb begin
    den_sh = REM_W'(div_i.den) << SHIFT;
    div_d  = div_i;
    if (div_i.rem >= den_sh) begin
      div_d.rem = div_i.rem - den_sh;
      div_d.quo = div_i.quo | (QBITS'(1) << SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

### hdl/csdm_cordic_cell.sv
// ----------------------------------------------------------------------------
// csdm_cordic_cell: one CORDIC rotation cell
// Rotates the vector by one table angle toward a zero residual angle.
// ----------------------------------------------------------------------------
module csdm_cordic_cell import csdm_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cord_t cord_i,
  output cord_t cord_o
);

  localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_turn(STEP));

  logic signed [CXY_W-1:0] dx;
  logic signed [CXY_W-1:0] dy;
  cord_t                   cord_d;
  cord_t                   cord_q;

  // Direction follows the sign of the residual angle.
  always_comb begin
    dx     = cord_i.cy >>> STEP;
    dy     = cord_i.cx >>> STEP;
    cord_d = cord_i;
    if (!cord_i.z[Z_W-1]) begin
      cord_d.cx = cord_i.cx - dx;
      cord_d.cy = cord_i.cy + dy;
      cord_d.z  = cord_i.z - ATAN;
    end else begin
      cord_d.cx = cord_i.cx + dx;
      cord_d.cy = cord_i.cy - dy;
      cord_d.z  = cord_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cord_q <= '0;
    end else if (en_i) begin
      cord_q <= cord_d;
    end
  end

  assign cord_o = cord_q;

endmodule

### hdl/concentric_square_to_disk_map_core.sv
// ----------------------------------------------------------------------------
// concentric_square_to_disk_map_core: concentric square-to-disk mapping
// Maps a unit-square sample to the unit disk through region select, a chain
// of division cells for the angle ratio and a chain of CORDIC cells.
// ----------------------------------------------------------------------------
//  Channel    Dir  Word
//  sample_i   in   sample_u, sample_v (unsigned, 16 fraction bits)
//  disk_o     out  disk_x, disk_y (signed, 16 fraction bits)
//
//  One word per cycle while the output is taken; the path runs through the
//  front stage, one cell per quotient bit, the angle and gain stages, one cell
//  per CORDIC step and the output buffer. A two-entry output buffer lets the
//  pipeline keep accepting while a result waits; the cell chain holds only when
//  both entries are full. Reset clears all valid bits and the buffer count.
// ----------------------------------------------------------------------------
module concentric_square_to_disk_map_core import csdm_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  csdm_sample_if.sink   sample_i,
  csdm_disk_if.source   disk_o
);

  localparam logic signed [XY_W-1:0] ONE = XY_W'(1) << FRAC_BITS;

  logic en;

  // Front stage: center, select region, set up the division.
  logic signed [XY_W-1:0] x, y, nx, ny, num, den, rad;
  oct_e                   oct;
  logic [XY_W-1:0]        num_mag, den_mag;
  div_t                   div_d;
  div_t                   div_w [0:QBITS];

  always_comb begin
    x   = signed'({1'b0, sample_i.sample_u, 1'b0}) - ONE;
    y   = signed'({1'b0, sample_i.sample_v, 1'b0}) - ONE;
    nx  = -x;
    ny  = -y;
    if (x > ny) begin
      if (x > y) begin
        rad = x;  num = y; den = x; oct = OCT0;
      end else begin
        rad = y;  num = x; den = y; oct = OCT2;
      end
    end else begin
      if (x < y) begin
        rad = nx; num = y; den = x; oct = OCT4;
      end else if (y != '0) begin
        rad = ny; num = x; den = y; oct = OCT6;
      end else begin
        // The center: radius and angle are both zero.
        rad = '0; num = '0; den = XY_W'(1); oct = OCT0;
      end
    end
    num_mag     = num[XY_W-1] ? XY_W'(-num) : XY_W'(num);
    den_mag     = den[XY_W-1] ? XY_W'(-den) : XY_W'(den);
    div_d.valid = sample_i.valid;
    div_d.rem   = REM_W'(num_mag[MAG_W-1:0]) << FRAC_BITS;
    div_d.den   = den_mag[MAG_W-1:0];
    div_d.quo   = '0;
    div_d.neg   = num[XY_W-1] ^ den[XY_W-1];
    div_d.oct   = oct;
    div_d.r     = rad[MAG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_w[0] <= '0;
    end else if (en) begin
      div_w[0] <= div_d;
    end
  end

  // Division cells, most significant quotient bit first.
  for (genvar i = 0; i < QBITS; i++) begin : g_div
    csdm_div_cell #(
      .SHIFT (QBITS - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .div_i  (div_w[i]),
      .div_o  (div_w[i+1])
    );
  end

  // Angle stage: octant offset plus signed ratio, fold into a quadrant.
  div_t                   dv;
  logic [ANG_W-1:0]       mag_ang, ang, ang_off;
  logic                   sub;
  logic [1:0]             quad_d;
  logic                   ang_vld_q;
  logic [1:0]             ang_quad_q;
  logic [ANG_W-1:0]       ang_z_q;
  logic [PROD_W-1:0]      ang_prod_q;

  always_comb begin
    dv      = div_w[QBITS];
    mag_ang = ANG_W'(dv.quo) << (OCT_SH - FRAC_BITS);
    sub     = dv.neg ^ ((dv.oct == OCT2) || (dv.oct == OCT6));
    ang     = (ANG_W'(dv.oct) << (OCT_SH + 1)) + (sub ? -mag_ang : mag_ang);
    ang_off = ang + (ANG_W'(1) << OCT_SH);
    quad_d  = ang_off[ANG_W-1 -: 2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_vld_q <= 1'b0;
    end else if (en) begin
      ang_vld_q <= dv.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_quad_q <= quad_d;
      ang_z_q    <= ang - (ANG_W'(quad_d) << (OCT_SH + 1));
      ang_prod_q <= PROD_W'(dv.r) * PROD_W'(KGAIN_Q30);
    end
  end

  // Gain stage: scaled start vector with the guard bits, rounded.
  logic [PROD_W-1:0] prod_rnd;
  cord_t             cord_w [0:CORDIC_STEPS];

  assign prod_rnd = ang_prod_q + (PROD_W'(1) << 13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cord_w[0] <= '0;
    end else if (en) begin
      cord_w[0].valid <= ang_vld_q;
      cord_w[0].quad  <= ang_quad_q;
      cord_w[0].cx    <= signed'(CXY_W'(prod_rnd >> 14));
      cord_w[0].cy    <= '0;
      cord_w[0].z     <= signed'({ang_z_q[ANG_W-1], ang_z_q});
    end
  end

  // CORDIC cells.
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
    csdm_cordic_cell #(
      .STEP (s)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cord_i (cord_w[s]),
      .cord_o (cord_w[s+1])
    );
  end

  // Drop guard bits, turn by the quadrant and saturate.
  localparam int unsigned RW = CXY_W - GUARD;
  localparam logic signed [RW-1:0] LIM = RW'(1) << FRAC_BITS;

  cord_t                    cf;
  logic signed [CXY_W-1:0]  cx_r, cy_r;
  logic signed [RW-1:0]     rx, ry, ox, oy;
  logic signed [OUT_W-1:0]  sx, sy;

  always_comb begin
    cf   = cord_w[CORDIC_STEPS];
    cx_r = (cf.cx + (CXY_W'(1) << (GUARD - 1))) >>> GUARD;
    cy_r = (cf.cy + (CXY_W'(1) << (GUARD - 1))) >>> GUARD;
    rx   = cx_r[RW-1:0];
    ry   = cy_r[RW-1:0];
    case (cf.quad)
      2'd0:    begin ox = rx;  oy = ry;  end
      2'd1:    begin ox = -ry; oy = rx;  end
      2'd2:    begin ox = -rx; oy = -ry; end
      default: begin ox = ry;  oy = -rx; end
    endcase
    if (ox > LIM)       sx = OUT_W'(LIM);
    else if (ox < -LIM) sx = OUT_W'(-LIM);
    else                sx = ox[OUT_W-1:0];
    if (oy > LIM)       sy = OUT_W'(LIM);
    else if (oy < -LIM) sy = OUT_W'(-LIM);
    else                sy = oy[OUT_W-1:0];
  end

  // Two-entry output buffer.
  logic signed [OUT_W-1:0] buf_x_q [0:1];
  logic signed [OUT_W-1:0] buf_y_q [0:1];
  logic                    wr_ptr_q, rd_ptr_q;
  logic [1:0]              cnt_q, cnt_d;
  logic                    push, pop;

  assign en   = (cnt_q != 2'd2);
  assign push = en && cf.valid;
  assign pop  = disk_o.valid && disk_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_x_q[wr_ptr_q] <= sx;
      buf_y_q[wr_ptr_q] <= sy;
    end
  end

  assign sample_i.ready = en;
  assign disk_o.valid   = (cnt_q != 2'd0);
  assign disk_o.disk_x  = buf_x_q[rd_ptr_q];
  assign disk_o.disk_y  = buf_y_q[rd_ptr_q];

  // Checks.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2))
    else $error("full output buffer changed without a pop");

  a_out_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disk_o.valid |-> (disk_o.disk_x <= OUT_W'(LIM) && disk_o.disk_x >= -OUT_W'(LIM)
                   && disk_o.disk_y <= OUT_W'(LIM) && disk_o.disk_y >= -OUT_W'(LIM)))
    else $error("disk word outside the unit range");

endmodule

### tb/tb_concentric_square_to_disk_map_core.sv
// ----------------------------------------------------------------------------
// tb_concentric_square_to_disk_map_core: testbench of the concentric disk mapper
// Drives sample words from a directed table and then at random, predicts each
// disk word in fixed point unless the table gives it, and compares it with the
// output, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_concentric_square_to_disk_map_core;
  import csdm_pkg::*;

  localparam int unsigned N_RANDOM  = 1630;
  localparam int unsigned LATENCY   = FRAC_BITS + CORDIC_STEPS_DEF + 5;
  localparam int unsigned NO_CHECK  = 0;
  localparam int unsigned DO_CHECK  = 1;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } disk_word_t;

  typedef struct {
    logic [IN_W-1:0] u;
    logic [IN_W-1:0] v;
    int unsigned     typed;  // DO_CHECK when the expected word is given below
    disk_word_t      disk;
  } sample_row_t;

  logic clk_i;
  logic rst_ni;
  int   errors;
  bit   no_idle;

  disk_word_t disk_q[$];

  csdm_sample_if sample_if ();
  csdm_disk_if   disk_if ();

  concentric_square_to_disk_map_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if.sink),
    .disk_o   (disk_if.source)
  );

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Arithmetic shift right with floor.
  function automatic longint shr_floor(input longint a, input int unsigned s);
    return a >>> s;
  endfunction

  // Signed ratio of num/den as an angle in 2^-32 turns per octant.
  function automatic longint octant_ratio(input longint num, input longint den);
    longint unsigned q;
    longint unsigned an;
    longint unsigned ad;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q  = (an << FRAC_BITS) / ad;
    q  = q << (OCT_SH - FRAC_BITS);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_unit(input longint a);
    if (a > 65536) return 65536;
    if (a < -65536) return -65536;
    return a;
  endfunction

  // Predicts the disk point of one unit-square sample.
  function automatic disk_word_t map_to_disk(input logic [IN_W-1:0] u,
                                             input logic [IN_W-1:0] v);
    longint     x, y, rad, ang, cx, cy, z, dx, dy, ox, oy;
    logic [31:0] t;
    logic [1:0]  quad;
    disk_word_t  w;
    x = longint'(u) * 2 - 65536;
    y = longint'(v) * 2 - 65536;
    if (x > -y) begin
      if (x > y) begin
        rad = x;
        ang = octant_ratio(y, x);
      end else begin
        rad = y;
        ang = 2 * (64'sd1 << OCT_SH) - octant_ratio(x, y);
      end
    end else begin
      if (x < y) begin
        rad = -x;
        ang = 4 * (64'sd1 << OCT_SH) + octant_ratio(y, x);
      end else begin
        rad = -y;
        ang = (y != 0) ? 6 * (64'sd1 << OCT_SH) - octant_ratio(x, y) : 0;
      end
    end
    t    = ang[31:0];
    quad = 2'((t + 32'h20000000) >> 30);
    z    = longint'(t) - longint'(quad) * 64'sh40000000;
    if (z >= 64'sh80000000) z -= 64'sh100000000;
    cx = (rad * longint'(KGAIN_Q30) + (64'sd1 << 13)) >>> 14;
    cy = 0;
    // Rotation toward zero residual angle.
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = shr_floor(cy, i);
      dy = shr_floor(cx, i);
      if (z >= 0) begin
        cx -= dx;
        cy += dy;
        z  -= longint'(atan_turn(i));
      end else begin
        cx += dx;
        cy -= dy;
        z  += longint'(atan_turn(i));
      end
    end
    cx = shr_floor(cx + (64'sd1 << (GUARD - 1)), GUARD);
    cy = shr_floor(cy + (64'sd1 << (GUARD - 1)), GUARD);
    case (quad)
      2'd0: begin ox = cx;  oy = cy;  end
      2'd1: begin ox = -cy; oy = cx;  end
      2'd2: begin ox = -cx; oy = -cy; end
      default: begin ox = cy; oy = -cx; end
    endcase
    w.x = OUT_W'(clamp_unit(ox));
    w.y = OUT_W'(clamp_unit(oy));
    return w;
  endfunction

  // Idles about a third of the cycles, except in the quiet stretch.
  function automatic bit take_gap();
    return !no_idle && ($urandom_range(99) < 33);
  endfunction

  // Sends one sample word and queues its expected disk word.
  task automatic send_sample(input logic [IN_W-1:0] u, input logic [IN_W-1:0] v,
                             input disk_word_t want);
    while (take_gap()) begin
      sample_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_if.valid    <= 1'b1;
    sample_if.sample_u <= u;
    sample_if.sample_v <= v;
    do @(posedge clk_i); while (!sample_if.ready);
    disk_q.insert(disk_q.size(), want);
    @(negedge clk_i);
  endtask

  // Directed table: corners, center, axes, diagonals and region edges.
  sample_row_t rows[] = '{
    '{16'h8000, 16'h8000, DO_CHECK, '{18'sd0, 18'sd0}},
    '{16'hFFFF, 16'h8000, DO_CHECK, '{18'sd65534, 18'sd0}},
    '{16'h0000, 16'h0000, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'hFFFF, 16'hFFFF, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h0000, 16'hFFFF, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'hFFFF, 16'h0000, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h0000, 16'h8000, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h8000, 16'h0000, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h8000, 16'hFFFF, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h8001, 16'h8000, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h7FFF, 16'h8000, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h8000, 16'h7FFF, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h8000, 16'h8001, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h7FFF, 16'h7FFF, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'hC000, 16'h4000, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h4000, 16'hC000, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'hFFFF, 16'hFFFE, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h5555, 16'hAAAA, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'hAAAA, 16'h5555, NO_CHECK, '{18'sd0, 18'sd0}},
    '{16'h0001, 16'hFFFE, NO_CHECK, '{18'sd0, 18'sd0}}
  };

  // Sample driver.
  initial begin
    disk_word_t want;
    logic [IN_W-1:0] u, v;
    int unsigned waited;
    sample_if.valid    = 1'b0;
    sample_if.sample_u = '0;
    sample_if.sample_v = '0;
    errors  = 0;
    no_idle = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    foreach (rows[i]) begin
      want = map_to_disk(rows[i].u, rows[i].v);
      if (rows[i].typed == DO_CHECK) want = rows[i].disk;
      send_sample(rows[i].u, rows[i].v, want);
    end
    // Hold off until the pipeline has drained.
    sample_if.valid <= 1'b0;
    while (disk_q.size() != 0) @(negedge clk_i);
    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = (n >= 600 && n < 800);
      case ($urandom_range(3))
        0: begin
          // Near a diagonal of the square.
          u = 16'($urandom);
          v = ($urandom_range(1)) ? u + 16'($urandom_range(2)) - 16'd1
                                  : 16'hFFFF - u + 16'($urandom_range(2)) - 16'd1;
        end
        1: begin
          u = ($urandom_range(1)) ? 16'h0000 + 16'($urandom_range(3))
                                  : 16'hFFFF - 16'($urandom_range(3));
          v = 16'($urandom);
        end
        default: begin
          u = 16'($urandom);
          v = 16'($urandom);
        end
      endcase
      if ($urandom_range(1)) {u, v} = {v, u};
      send_sample(u, v, map_to_disk(u, v));
    end
    sample_if.valid <= 1'b0;
    waited = 0;
    while (disk_q.size() != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (LATENCY + 10) @(negedge clk_i);
    if (errors == 0 && disk_q.size() == 0) begin
      $display("PASS concentric_square_to_disk_map_core");
    end else begin
      $display("FAIL concentric_square_to_disk_map_core");
    end
    $finish;
  end

  // Disk word receiver with random stalls.
  initial begin
    disk_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      disk_if.ready <= !take_gap();
    end
  end

  // Disk word checker.
  always @(posedge clk_i) begin
    disk_word_t want;
    if (rst_ni && disk_if.valid && disk_if.ready) begin
      if (disk_q.size() == 0) begin
        $error("disk word with no sample pending: x=%0d y=%0d",
               disk_if.disk_x, disk_if.disk_y);
        errors++;
      end else begin
        want = disk_q.pop_front();
        if (disk_if.disk_x !== want.x) begin
          $error("disk_x expected %0d actual %0d", want.x, disk_if.disk_x);
          errors++;
        end
        if (disk_if.disk_y !== want.y) begin
          $error("disk_y expected %0d actual %0d", want.y, disk_if.disk_y);
          errors++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #5ms;
    $display("FAIL concentric_square_to_disk_map_core");
    $finish;
  end

endmodule

### files.f
hdl/csdm_pkg.sv
hdl/csdm_if.sv
hdl/csdm_div_cell.sv
hdl/csdm_cordic_cell.sv
hdl/concentric_square_to_disk_map_core.sv
tb/tb_concentric_square_to_disk_map_core.sv
